// ----- rtl/frid_pkg.sv -----
// Shared types and constants for the recent-identifier window.
// Used by frid_ctrl, frid_datapath and fifo_recent_id_window_core.
package frid_pkg;

	// Window geometry.
	localparam int WINDOW_DEPTH = 16;
	localparam int ID_BITS      = 32;
	localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

	// Fixed field widths on the ports.
	localparam int CAP_W        = 5;
	localparam int SID_W        = 32;
	localparam int HELD_W       = 5;
	localparam int IN_TDATA_W   = 32;
	localparam int OUT_FIELDS_W = 1 + 1 + SID_W + HELD_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Reset value of the capacity register.
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture the incoming identifier
		logic exec;   // look up, update the window and register the result
	} frid_cmd_t;

endpackage

// ----- rtl/fifo_recent_id_window_core.sv -----
// Recent-identifier window with FIFO replacement: one result word per input word.
// Each input word is captured, then looked up and the window updated, which registers its result.
// The lookup waits while an earlier result is held; no new word is taken until the lookup is done.
// The output register lets the next input word in while a result waits.
// Reset (arst_n low) empties the window, zeroes the oldest pointer, sets capacity to 16.
// Holds frid_ctrl and frid_datapath; depends on frid_pkg.
module fifo_recent_id_window_core
	import frid_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// Input stream.
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] sender_id
	// Result stream.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [0] already_held, [1] evict_valid, [33:2] evicted_id, [38:34] held_count, [39] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// Capacity register.
	input  logic                   cfg_we,
	input  logic [CAP_W-1:0]       cfg_data
);

	frid_cmd_t cmd;

	// Sequencing and handshakes.
	frid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// Window storage and lookup.
	frid_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.s_tdata  (s_tdata),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.m_tdata  (m_tdata)
	);

endmodule

// ----- rtl/frid_ctrl.sv -----
// Controller for the recent-identifier window: sequences load and lookup
// and owns the stream handshakes. Depends on frid_pkg.
module frid_ctrl
	import frid_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	output frid_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// A new word is taken whenever no lookup is pending.
	assign s_tready = (state_q == ST_IDLE);
	assign cmd.load = s_tvalid && s_tready;

	// The lookup runs once the output register is free or is being drained.
	assign cmd.exec = (state_q == ST_EXEC) && (!out_valid_q || m_tready);

	assign m_tvalid = out_valid_q;

	// State and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_EXEC;
					end
					if (m_tready) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_EXEC: begin
					if (cmd.exec) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/frid_datapath.sv -----
// Datapath for the recent-identifier window: slot storage, parallel compare,
// FIFO replacement pointers, capacity register and result register.
// Depends on frid_pkg.
module frid_datapath
	import frid_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  frid_cmd_t              cmd,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   cfg_we,
	input  logic [CAP_W-1:0]       cfg_data,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int SUM_W = CNT_W + 1;

	logic [ID_BITS-1:0]      ids_q [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0] valid_q;
	logic [IDX_W-1:0]        oldest_q;
	logic [CNT_W-1:0]        count_q;
	logic [CAP_W-1:0]        cap_q;
	logic [ID_BITS-1:0]      id_q;

	logic [WINDOW_DEPTH-1:0] match;
	logic                    hit;
	logic [CNT_W-1:0]        cap_eff;
	logic                    full;
	logic [SUM_W-1:0]        pos_sum;
	logic [IDX_W-1:0]        pos;
	logic [IDX_W-1:0]        oldest_next;
	logic [CNT_W-1:0]        count_next;
	logic                    evict;

	logic                    hit_q;
	logic                    evict_q;
	logic [SID_W-1:0]        gone_q;
	logic [HELD_W-1:0]       held_q;

	// Compare the identifier against every valid slot.
	always_comb begin
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			match[i] = valid_q[i] && (ids_q[i] == id_q);
		end
	end
	assign hit = |match;

	// Clamp capacity to the range one to the window depth.
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (32'(cap_q) > 32'(WINDOW_DEPTH)) begin
			cap_eff = CNT_W'(WINDOW_DEPTH);
		end else begin
			cap_eff = CNT_W'(cap_q);
		end
	end
	assign full  = (count_q >= cap_eff);
	assign evict = !hit && full;

	// Insertion slot just past the newest entry, wrapped around the window.
	assign pos_sum = SUM_W'(oldest_q) + SUM_W'(count_q);
	assign pos = (pos_sum >= SUM_W'(WINDOW_DEPTH)) ?
		IDX_W'(pos_sum - SUM_W'(WINDOW_DEPTH)) : IDX_W'(pos_sum);

	assign oldest_next = (oldest_q == IDX_W'(WINDOW_DEPTH - 1)) ?
		'0 : IDX_W'(oldest_q + IDX_W'(1));

	assign count_next = (hit || full) ? count_q : CNT_W'(count_q + CNT_W'(1));

	// Window control state and capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			oldest_q <= '0;
			count_q  <= '0;
			cap_q    <= CAP_RESET;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (cmd.exec && !hit) begin
				if (full) begin
					valid_q[oldest_q] <= 1'b0;
					oldest_q          <= oldest_next;
				end
				// Setting the new slot last keeps it valid when it reuses the oldest.
				valid_q[pos] <= 1'b1;
				count_q      <= count_next;
			end
		end
	end

	// Identifier capture and slot writes.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q <= ID_BITS'(s_tdata);
		end
		if (cmd.exec && !hit) begin
			ids_q[pos] <= id_q;
		end
	end

	// Result register, loaded by each lookup.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			hit_q   <= hit;
			evict_q <= evict;
			gone_q  <= evict ? SID_W'(ids_q[oldest_q]) : '0;
			held_q  <= HELD_W'(count_next);
		end
	end

	assign m_tdata = OUT_TDATA_W'({held_q, gone_q, evict_q, hit_q});

`ifndef SYNTHESIS
	// Occupancy never exceeds the window.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(WINDOW_DEPTH))
		else $error("window occupancy above depth");

	// Valid bits and the occupancy counter agree.
	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == 32'(count_q))
		else $error("valid bits disagree with occupancy");

	// A hit leaves the window untouched.
	a_hit_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && hit) |=> ($stable(count_q) && $stable(oldest_q) && $stable(valid_q)))
		else $error("window changed on a hit");

	// An eviction only happens with a full window and advances the oldest slot.
	a_evict_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && evict) |=> (oldest_q == $past(oldest_next)))
		else $error("oldest slot not advanced on eviction");
`endif

endmodule
